// ===== design/imm_pkg.sv =====
// Shared types and constants for the integer matrix multiplier.
`default_nettype none

package imm_pkg;

   localparam int MAX_DIM_DEFAULT = 8;   // default store side length
   localparam int DATA_W          = 32;  // element and sum width
   localparam int DIM_W           = 4;   // dimension register width
   localparam int IDX_W           = 3;   // row / column index width
   localparam int REQ_W           = 2;   // request code width
   localparam int CSR_IDX_W       = 2;   // register index width

   // request codes
   localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WRITE_C = 2'd1;
   localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_B    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_C    = 2'd2;

   // control that travels beside one multiply-accumulate step
   typedef struct packed {
      logic             valid;
      logic             first_k;    // first term of a dot product
      logic             last_k;     // last term of a dot product
      logic             last_elem;  // final element of the product
      logic             zero;       // empty inner dimension: term is zero
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } step_ctl_type;

endpackage

`default_nettype wire

// ===== design/integer_matrix_multiply_top.sv =====
// Top level of the integer matrix multiplier: operand stores and MAC pipeline.
`default_nettype none

// Integer matrix multiplier, A = B x C, 32-bit wrapping arithmetic.
// Requests are taken at a rising edge with start high and busy low. A write
// request (B or C) stores one element at row * MAX_DIM + column and leaves
// busy low, so loads can stream one per cycle while no compute holds busy
// high; indices not below MAX_DIM are dropped. A compute request raises busy
// and walks the product in row-major order, issuing one multiply-accumulate
// step per cycle: one read of each store, a registered 32x32 multiply, then
// an accumulate. Each element takes one step per term of its dot product, or
// a single zero step when inner_dim is zero; the single read port of each
// store sets that pace. Each result is shown on the rsp_ ports for exactly
// one cycle, marked by rsp_strobe; the receiver cannot stall, so capture
// every strobe. The final element carries rsp_last_flag. Busy falls in the
// cycle of the final strobe, and the next request may be taken at the edge
// that ends it. A compute with rows_b or cols_c zero emits nothing and does
// not raise busy. Dimension registers saturate at the smaller of MAX_DIM and
// 8 and must be written only while busy is low. Store contents are undefined
// until written; computing over unwritten elements returns unspecified
// values.
module integer_matrix_multiply_top #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [imm_pkg::REQ_W-1:0]          req_type,
   input  wire logic [imm_pkg::IDX_W-1:0]          req_row_idx,
   input  wire logic [imm_pkg::IDX_W-1:0]          req_col_idx,
   input  wire logic signed [imm_pkg::DATA_W-1:0]  req_elem_value,
   // result channel
   output logic                                    rsp_strobe,
   output logic [imm_pkg::IDX_W-1:0]               rsp_out_row,
   output logic [imm_pkg::IDX_W-1:0]               rsp_out_col,
   output logic signed [imm_pkg::DATA_W-1:0]       rsp_result_value,
   output logic                                    rsp_last_flag,
   // configuration port
   input  wire logic                               csr_write_en,
   input  wire logic [imm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [imm_pkg::DIM_W-1:0]          csr_write_data
);

   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

   localparam logic [imm_pkg::DIM_W-1:0] DIM_CAP_V = imm_pkg::DIM_W'(DIM_CAP);
   localparam logic [imm_pkg::DIM_W-1:0] DIM_ONE   = imm_pkg::DIM_W'(1);
   localparam logic [imm_pkg::IDX_W-1:0] IDX_ONE   = imm_pkg::IDX_W'(1);
   localparam logic [ADDR_W-1:0]         STRIDE    = ADDR_W'(MAX_DIM);

   // ------------------------------------------------------------------
   // Dimension registers
   // ------------------------------------------------------------------
   logic [imm_pkg::DIM_W-1:0] rows_b_ff, inner_dim_ff, cols_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_b_ff    <= DIM_ONE;
         inner_dim_ff <= DIM_ONE;
         cols_c_ff    <= DIM_ONE;
      end else if (csr_write_en) begin
         unique case (csr_index)
            imm_pkg::CSR_ROWS_B:    rows_b_ff    <= csr_write_data;
            imm_pkg::CSR_INNER_DIM: inner_dim_ff <= csr_write_data;
            imm_pkg::CSR_COLS_C:    cols_c_ff    <= csr_write_data;
            default: ;  // unused index: drop the write
         endcase
      end
   end

   // saturate a dimension to the smaller of MAX_DIM and 8
   function automatic logic [imm_pkg::DIM_W-1:0] sat_dim(input logic [imm_pkg::DIM_W-1:0] v);
      return (v > DIM_CAP_V) ? DIM_CAP_V : v;
   endfunction

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   logic accept;
   logic in_range;
   logic write_b, write_c, compute_go;
   logic [ADDR_W-1:0] wr_addr;
   logic [imm_pkg::DIM_W-1:0] nr_sat, nk_sat, nc_sat;

   assign accept   = start && !busy;
   assign in_range = (32'(req_row_idx) < 32'(MAX_DIM)) && (32'(req_col_idx) < 32'(MAX_DIM));
   assign write_b  = accept && in_range && (req_type == imm_pkg::REQ_WRITE_B);
   assign write_c  = accept && in_range && (req_type == imm_pkg::REQ_WRITE_C);
   assign wr_addr  = ADDR_W'(req_row_idx) * STRIDE + ADDR_W'(req_col_idx);

   assign nr_sat = sat_dim(rows_b_ff);
   assign nk_sat = sat_dim(inner_dim_ff);
   assign nc_sat = sat_dim(cols_c_ff);

   // an empty result matrix starts nothing
   assign compute_go = accept && (req_type == imm_pkg::REQ_COMPUTE)
                       && (nr_sat != '0) && (nc_sat != '0);

   // ------------------------------------------------------------------
   // Issue stage: walk i, j, k and read one term of each operand
   // ------------------------------------------------------------------
   logic                      running_ff, running_in;
   logic [imm_pkg::IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [imm_pkg::DIM_W-1:0] nr_ff, nk_ff, nc_ff;
   logic                      k_last, j_last, i_last;
   logic [ADDR_W-1:0]         b_raddr, c_raddr;
   imm_pkg::step_ctl_type     issue_ctl;

   assign k_last = (nk_ff == '0) || ({1'b0, k_ff} == nk_ff - DIM_ONE);
   assign j_last = ({1'b0, j_ff} == nc_ff - DIM_ONE);
   assign i_last = ({1'b0, i_ff} == nr_ff - DIM_ONE);

   assign b_raddr = ADDR_W'(i_ff) * STRIDE + ADDR_W'(k_ff);
   assign c_raddr = ADDR_W'(k_ff) * STRIDE + ADDR_W'(j_ff);

   always_comb begin
      issue_ctl.valid     = running_ff;
      issue_ctl.first_k   = (k_ff == '0);
      issue_ctl.last_k    = k_last;
      issue_ctl.last_elem = k_last && j_last && i_last;
      issue_ctl.zero      = (nk_ff == '0);
      issue_ctl.row       = i_ff;
      issue_ctl.col       = j_ff;
   end

   always_comb begin
      running_in = running_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      if (compute_go) begin
         running_in = 1'b1;
         i_in       = '0;
         j_in       = '0;
         k_in       = '0;
      end else if (running_ff) begin
         // advance k, then j, then i; stop after the final step
         if (!k_last) begin
            k_in = k_ff + IDX_ONE;
         end else begin
            k_in = '0;
            if (!j_last) begin
               j_in = j_ff + IDX_ONE;
            end else begin
               j_in = '0;
               if (!i_last) begin
                  i_in = i_ff + IDX_ONE;
               end else begin
                  running_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      if (compute_go) begin
         // hold the dimensions for the whole product
         nr_ff <= nr_sat;
         nk_ff <= nk_sat;
         nc_ff <= nc_sat;
      end
   end

   // ------------------------------------------------------------------
   // Operand stores: one write port, one registered read port each.
   // Writes are taken only while idle, so no read can overlap a write.
   // ------------------------------------------------------------------
   logic [imm_pkg::DATA_W-1:0] b_mem [DEPTH];
   logic [imm_pkg::DATA_W-1:0] c_mem [DEPTH];
   logic [imm_pkg::DATA_W-1:0] b_rd_ff, c_rd_ff;

   always_ff @(posedge clock) begin
      if (write_b) begin
         b_mem[wr_addr] <= req_elem_value;
      end
      b_rd_ff <= b_mem[b_raddr];
   end

   always_ff @(posedge clock) begin
      if (write_c) begin
         c_mem[wr_addr] <= req_elem_value;
      end
      c_rd_ff <= c_mem[c_raddr];
   end

   // ------------------------------------------------------------------
   // Multiply stage and accumulate stage
   // ------------------------------------------------------------------
   imm_pkg::step_ctl_type      rd_ctl_ff, mul_ctl_ff;
   logic [imm_pkg::DATA_W-1:0] prod_ff, prod_in;
   logic [imm_pkg::DATA_W-1:0] acc_ff, acc_in;

   // low word of the product is all that survives the wrap
   assign prod_in = rd_ctl_ff.zero ? '0 : b_rd_ff * c_rd_ff;
   assign acc_in  = mul_ctl_ff.first_k ? prod_ff : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ctl_ff  <= '0;
         mul_ctl_ff <= '0;
      end else begin
         rd_ctl_ff  <= issue_ctl;
         mul_ctl_ff <= rd_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (mul_ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register: one strobe per finished dot product
   // ------------------------------------------------------------------
   logic                       rsp_strobe_ff;
   logic [imm_pkg::IDX_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic [imm_pkg::DATA_W-1:0] rsp_value_ff;
   logic                       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= mul_ctl_ff.valid && mul_ctl_ff.last_k;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ctl_ff.valid && mul_ctl_ff.last_k) begin
         rsp_row_ff   <= mul_ctl_ff.row;
         rsp_col_ff   <= mul_ctl_ff.col;
         rsp_value_ff <= acc_in;
         rsp_last_ff  <= mul_ctl_ff.last_elem;
      end
   end

   assign busy             = running_ff || rd_ctl_ff.valid || mul_ctl_ff.valid;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last_flag    = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/imm_checker.sv =====
// Port-level checks for the integer matrix multiplier, bound to the top level.
`default_nettype none

module imm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic [imm_pkg::REQ_W-1:0]     req_type,
   input wire logic                          rsp_strobe,
   input wire logic                          rsp_last_flag
);

   // more elements follow a non-final result, so the block stays busy
   a_mid_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_flag |-> busy)
      else $error("non-final result while idle");

   // busy drops only together with the final result
   a_busy_fall_last: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe && rsp_last_flag)
      else $error("busy fell without the final result");

   // nothing trails the final result
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_flag |=> !rsp_strobe)
      else $error("result after the final element");

   // a store write produces no result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == imm_pkg::REQ_WRITE_B || req_type == imm_pkg::REQ_WRITE_C)
      |=> !rsp_strobe)
      else $error("result after a store write");

endmodule

bind integer_matrix_multiply_top imm_checker u_imm_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_type      (req_type),
   .rsp_strobe    (rsp_strobe),
   .rsp_last_flag (rsp_last_flag)
);

`default_nettype wire

// ===== bench/tb_integer_matrix_multiply_top.sv =====
// Self-checking testbench for the integer matrix multiplier top level.
`default_nettype none

module tb_integer_matrix_multiply_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W    = imm_pkg::DATA_W;
   localparam int DIM_W     = imm_pkg::DIM_W;
   localparam int IDX_W     = imm_pkg::IDX_W;
   localparam int REQ_W     = imm_pkg::REQ_W;
   localparam int CSR_IDX_W = imm_pkg::CSR_IDX_W;

   localparam int SIDE        = imm_pkg::MAX_DIM_DEFAULT;
   localparam int DIM_CAP     = (SIDE < 8) ? SIDE : 8;
   localparam int ITEM_TARGET = 230;   // requests in the whole run, ignored codes not counted
   localparam int TAIL_CYCLES = 8;     // covers the three-stage MAC pipeline and then some
   localparam int MAX_REPORTS = 10;

   // request code and register index the block has no use for
   localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // how a directed compute is checked: by the predictor, as silent, or as one typed element
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_type;
   typedef enum logic {ACT_CSR, ACT_REQ} action_type;

   typedef struct packed {
      action_type           act;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [DIM_W-1:0]     reg_val;
      logic [REQ_W-1:0]     kind;
      logic [IDX_W-1:0]     row;
      logic [IDX_W-1:0]     col;
      logic [DATA_W-1:0]    value;
      check_type            chk;
      logic [DATA_W-1:0]    typed;
   } step_row_type;

   typedef struct packed {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] value;
      logic              last;
   } product_elem_type;

   // ---------------------------------------------------------------- signals
   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     start          = 1'b0;
   logic                     busy;
   logic [REQ_W-1:0]         req_type       = imm_pkg::REQ_WRITE_B;
   logic [IDX_W-1:0]         req_row_idx    = '0;
   logic [IDX_W-1:0]         req_col_idx    = '0;
   logic signed [DATA_W-1:0] req_elem_value = '0;
   logic                     rsp_strobe;
   logic [IDX_W-1:0]         rsp_out_row;
   logic [IDX_W-1:0]         rsp_out_col;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic                     rsp_last_flag;
   logic                     csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index      = imm_pkg::CSR_ROWS_B;
   logic [DIM_W-1:0]         csr_write_data = '0;

   integer_matrix_multiply_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_row_idx      (req_row_idx),
      .req_col_idx      (req_col_idx),
      .req_elem_value   (req_elem_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_result_value (rsp_result_value),
      .rsp_last_flag    (rsp_last_flag),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------- predictor state
   // Shadow copies of both operand stores, the dimension registers as last
   // written, and which store entries hold a known value since reset.
   logic [DATA_W-1:0] b_elem   [SIDE*SIDE];
   logic [DATA_W-1:0] c_elem   [SIDE*SIDE];
   bit                b_loaded [SIDE*SIDE];
   bit                c_loaded [SIDE*SIDE];
   logic [DIM_W-1:0]  dim_rows  = 4'd1;
   logic [DIM_W-1:0]  dim_inner = 4'd1;
   logic [DIM_W-1:0]  dim_cols  = 4'd1;

   product_elem_type product_queue[$];   // product elements still to arrive, oldest first

   int unsigned idle_pct     = 0;
   int unsigned items_sent   = 0;
   int unsigned products     = 0;
   int unsigned settings     = 0;
   int unsigned results_seen = 0;
   int unsigned errors       = 0;

   // ------------------------------------------------------- directed table
   // Start from the reset dimensions (1 x 1 x 1), so single products can be
   // typed in: largest positive squared wraps to 1, most negative squared
   // wraps to 0, most negative times -1 wraps to itself. Then: an unused
   // code that must not touch the store, a write to the unused register
   // index, empty inner dimension, empty rows and empty columns, and a
   // column count above the cap that must saturate to eight.
   localparam int N_DIRECTED = 29;
   step_row_type directed_tab [N_DIRECTED] = '{
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_B, 3'd0, 3'd0,
        32'h7FFF_FFFF, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_C, 3'd0, 3'd0,
        32'h7FFF_FFFF, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_COMPUTE, 3'd7, 3'd7,
        32'hFFFF_FFFF, CHK_ONE, 32'h0000_0001},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_B, 3'd0, 3'd0,
        32'h8000_0000, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_C, 3'd0, 3'd0,
        32'h8000_0000, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_COMPUTE, 3'd0, 3'd0,
        32'h0000_0000, CHK_ONE, 32'h0000_0000},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_C, 3'd0, 3'd0,
        32'hFFFF_FFFF, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_COMPUTE, 3'd5, 3'd2,
        32'h1234_5678, CHK_ONE, 32'h8000_0000},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, REQ_UNUSED, 3'd0, 3'd0,
        32'h5A5A_5A5A, CHK_NONE, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_COMPUTE, 3'd0, 3'd0,
        32'h0000_0000, CHK_ONE, 32'h8000_0000},
      '{ACT_CSR, CSR_UNUSED, 4'd0, imm_pkg::REQ_WRITE_B, 3'd0, 3'd0,
        32'h0, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_COMPUTE, 3'd0, 3'd0,
        32'h0000_0000, CHK_ONE, 32'h8000_0000},
      '{ACT_CSR, imm_pkg::CSR_INNER_DIM, 4'd0, imm_pkg::REQ_WRITE_B, 3'd0, 3'd0,
        32'h0, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_COMPUTE, 3'd0, 3'd0,
        32'h0000_0000, CHK_ONE, 32'h0000_0000},
      '{ACT_CSR, imm_pkg::CSR_INNER_DIM, 4'd1, imm_pkg::REQ_WRITE_B, 3'd0, 3'd0,
        32'h0, CHK_MODEL, 32'h0},
      '{ACT_CSR, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_B, 3'd0, 3'd0,
        32'h0, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_COMPUTE, 3'd0, 3'd0,
        32'h0000_0000, CHK_NONE, 32'h0},
      '{ACT_CSR, imm_pkg::CSR_ROWS_B, 4'd1, imm_pkg::REQ_WRITE_B, 3'd0, 3'd0,
        32'h0, CHK_MODEL, 32'h0},
      '{ACT_CSR, imm_pkg::CSR_COLS_C, 4'd0, imm_pkg::REQ_WRITE_B, 3'd0, 3'd0,
        32'h0, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_COMPUTE, 3'd0, 3'd0,
        32'h0000_0000, CHK_NONE, 32'h0},
      '{ACT_CSR, imm_pkg::CSR_COLS_C, 4'd15, imm_pkg::REQ_WRITE_B, 3'd0, 3'd0,
        32'h0, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_C, 3'd0, 3'd1,
        32'h0000_0001, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_C, 3'd0, 3'd2,
        32'hFFFF_FFFF, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_C, 3'd0, 3'd3,
        32'h7FFF_FFFF, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_C, 3'd0, 3'd4,
        32'h8000_0000, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_C, 3'd0, 3'd5,
        32'h0000_0002, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_C, 3'd0, 3'd6,
        32'h1234_5678, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_WRITE_C, 3'd0, 3'd7,
        32'hFFFF_0000, CHK_MODEL, 32'h0},
      '{ACT_REQ, imm_pkg::CSR_ROWS_B, 4'd0, imm_pkg::REQ_COMPUTE, 3'd3, 3'd6,
        32'hDEAD_BEEF, CHK_MODEL, 32'h0}
   };

   // ------------------------------------------------------------ predictor
   function automatic int unsigned clip_dim(input logic [DIM_W-1:0] v);
      return (v > DIM_CAP) ? DIM_CAP : int'(v);
   endfunction

   // Walk the product row-major, one wrapped dot product per element; the
   // element that closes the product carries the last flag.
   function automatic void predict_product();
      int unsigned       nr;
      int unsigned       nk;
      int unsigned       nc;
      int unsigned       count;
      logic [DATA_W-1:0] acc;
      product_elem_type  elem;
      nr    = clip_dim(dim_rows);
      nk    = clip_dim(dim_inner);
      nc    = clip_dim(dim_cols);
      count = 0;
      for (int unsigned i = 0; i < nr; i++) begin
         for (int unsigned j = 0; j < nc; j++) begin
            acc = '0;
            for (int unsigned k = 0; k < nk; k++)
               acc = acc + b_elem[i*SIDE + k] * c_elem[k*SIDE + j];
            count++;
            elem.row   = IDX_W'(i);
            elem.col   = IDX_W'(j);
            elem.value = acc;
            elem.last  = (count == nr * nc);
            product_queue.push_back(elem);
         end
      end
   endfunction

   // Update the shadow stores for an accepted request, or queue its products.
   function automatic void apply_request(input logic [REQ_W-1:0]  kind,
                                         input logic [IDX_W-1:0]  row,
                                         input logic [IDX_W-1:0]  col,
                                         input logic [DATA_W-1:0] value,
                                         input check_type         chk,
                                         input logic [DATA_W-1:0] typed);
      int unsigned      addr;
      product_elem_type elem;
      addr = row * SIDE + col;
      case (kind)
         imm_pkg::REQ_WRITE_B: begin
            b_elem[addr]   = value;
            b_loaded[addr] = 1'b1;
         end
         imm_pkg::REQ_WRITE_C: begin
            c_elem[addr]   = value;
            c_loaded[addr] = 1'b1;
         end
         imm_pkg::REQ_COMPUTE: begin
            products++;
            if (chk == CHK_MODEL) begin
               predict_product();
            end else if (chk == CHK_ONE) begin
               elem.row   = '0;
               elem.col   = '0;
               elem.value = typed;
               elem.last  = 1'b1;
               product_queue.push_back(elem);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void log_error(input string msg);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // ------------------------------------------------------------- checker
   // Results cannot be held off, so take every strobe at the edge ending it
   // and match it against the oldest waiting product element.
   always @(posedge clock) begin : check_results
      product_elem_type got;
      product_elem_type want;
      if (!reset && rsp_strobe) begin
         got.row   = rsp_out_row;
         got.col   = rsp_out_col;
         got.value = rsp_result_value;
         got.last  = rsp_last_flag;
         results_seen++;
         if (product_queue.size() == 0) begin
            log_error($sformatf("unexpected result row %0d col %0d value %h last %b",
                                got.row, got.col, got.value, got.last));
         end else begin
            want = product_queue.pop_front();
            if (got.row !== want.row || got.col !== want.col ||
                got.value !== want.value || got.last !== want.last)
               log_error($sformatf(
                  "expected row %0d col %0d value %h last %b, got %0d %0d %h %b",
                  want.row, want.col, want.value, want.last,
                  got.row, got.col, got.value, got.last));
         end
      end
   end

   // -------------------------------------------------------------- drivers
   // All drivers run from a rising-edge time step and return in one.

   // Present one request and hold it until an edge sees start high and busy
   // low; then account for it and, at random, drop start so the sender sits
   // idle in about idle_pct cycles of a hundred.
   task automatic issue(input logic [REQ_W-1:0]  kind,
                        input logic [IDX_W-1:0]  row,
                        input logic [IDX_W-1:0]  col,
                        input logic [DATA_W-1:0] value,
                        input check_type         chk,
                        input logic [DATA_W-1:0] typed);
      start          <= 1'b1;
      req_type       <= kind;
      req_row_idx    <= row;
      req_col_idx    <= col;
      req_elem_value <= value;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      apply_request(kind, row, col, value, chk, typed);
      if (kind != REQ_UNUSED)
         items_sent++;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Drop start and wait until every product element has arrived, then give
   // a trailing write request or silent compute time to finish.
   task automatic settle();
      start <= 1'b0;
      while (product_queue.size() != 0 || busy)
         @(posedge clock);
      repeat (TAIL_CYCLES)
         @(posedge clock);
   endtask

   // Pulse one register write, then let the enable fall before returning, so
   // back-to-back writes never lower and raise the enable in one step.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      @(posedge clock);
      case (idx)
         imm_pkg::CSR_ROWS_B:    dim_rows  = val;
         imm_pkg::CSR_INNER_DIM: dim_inner = val;
         imm_pkg::CSR_COLS_C:    dim_cols  = val;
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // --------------------------------------------------------- random stimulus
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return 32'h0000_0001;
         2:       return '1;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h8000_0000;
         5:       return DATA_W'($urandom_range(16)) - 32'd8;
         default: return $urandom;
      endcase
   endfunction

   // Mostly small sides; now and then empty, now and then at or above the cap.
   function automatic logic [DIM_W-1:0] pick_dim();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 6)
         return '0;
      if (roll < 12)
         return DIM_W'($urandom_range(8, 15));
      return DIM_W'($urandom_range(1, 4));
   endfunction

   // One load-then-compute round: fill every operand the product reads that
   // is still unknown, refresh about half the rest, scatter some noise, then
   // compute. Occasionally hold off until the whole product has drained.
   task automatic run_round();
      int unsigned nr;
      int unsigned nk;
      int unsigned nc;
      nr = clip_dim(dim_rows);
      nk = clip_dim(dim_inner);
      nc = clip_dim(dim_cols);
      for (int unsigned i = 0; i < nr; i++)
         for (int unsigned k = 0; k < nk; k++)
            if (!b_loaded[i*SIDE + k] || $urandom_range(1) == 0)
               issue(imm_pkg::REQ_WRITE_B, IDX_W'(i), IDX_W'(k), pick_value(),
                     CHK_MODEL, '0);
      for (int unsigned k = 0; k < nk; k++)
         for (int unsigned j = 0; j < nc; j++)
            if (!c_loaded[k*SIDE + j] || $urandom_range(1) == 0)
               issue(imm_pkg::REQ_WRITE_C, IDX_W'(k), IDX_W'(j), pick_value(),
                     CHK_MODEL, '0);
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(2))
            0: issue(imm_pkg::REQ_WRITE_B, IDX_W'($urandom), IDX_W'($urandom),
                     pick_value(), CHK_MODEL, '0);
            1: issue(imm_pkg::REQ_WRITE_C, IDX_W'($urandom), IDX_W'($urandom),
                     pick_value(), CHK_MODEL, '0);
            default: issue(REQ_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom,
                           CHK_NONE, '0);
         endcase
      end
      issue(imm_pkg::REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom,
            CHK_MODEL, '0);
      if ($urandom_range(5) == 0)
         settle();
   endtask

   // ------------------------------------------------------------ main flow
   initial begin : main_flow
      int unsigned random_base;
      int unsigned random_span;
      int unsigned done;
      int unsigned guard;
      repeat (11)
         @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; register rows only once the block is idle.
      foreach (directed_tab[n]) begin
         if (directed_tab[n].act == ACT_CSR) begin
            settle();
            write_reg(directed_tab[n].reg_idx, directed_tab[n].reg_val);
            settings++;
         end else begin
            issue(directed_tab[n].kind, directed_tab[n].row, directed_tab[n].col,
                  directed_tab[n].value, directed_tab[n].chk, directed_tab[n].typed);
         end
      end

      // Random phases: new dimensions, then a few load-and-compute rounds,
      // until the whole run reaches its request count.
      // Sender gaps go 21 percent, then 53 percent, then none.
      random_base = items_sent;
      random_span = (ITEM_TARGET > random_base) ? ITEM_TARGET - random_base : 1;
      done        = 0;
      while (done < random_span) begin
         idle_pct = (done < random_span / 3)     ? 21 :
                    (done < 2 * random_span / 3) ? 53 : 0;
         settle();
         write_reg(imm_pkg::CSR_ROWS_B,    pick_dim());
         write_reg(imm_pkg::CSR_INNER_DIM, pick_dim());
         write_reg(imm_pkg::CSR_COLS_C,    pick_dim());
         settings++;
         repeat ($urandom_range(1, 3))
            run_round();
         done = items_sent - random_base;
      end

      // Drain with a bound, then give the pipeline its tail.
      start <= 1'b0;
      guard  = 0;
      while (product_queue.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES)
         @(posedge clock);
      if (product_queue.size() != 0)
         log_error($sformatf("%0d product elements never arrived", product_queue.size()));

      $display("Covered %0d requests with %0d computes over %0d dimension settings,",
               items_sent, products, settings);
      $display("checking %0d product elements with sender gaps of 21, 53 and 0 percent.",
               results_seen);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d errors in total", errors);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #10_000_000;
      $display("timeout: %0d product elements still pending", product_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
